// ===== hw/rtl/mbh_pkg.sv =====
// shared constants and types for the modular byte hash
`timescale 1ns / 1ps
`default_nettype none

package mbh_pkg;

    // default configuration
    localparam int VALUE_WIDTH_DEF     = 63;
    localparam int CONSTANT_ROUNDS_DEF = 16;

    // fixed field widths of the ports
    localparam int MOD_FIELD_W  = 63;
    localparam int BYTE_W       = 8;
    localparam int OUT_TDATA_W  = 64;

    // modulus after reset, 2^61 - 1
    localparam logic [MOD_FIELD_W-1:0] MODULUS_RESET = 63'h1FFF_FFFF_FFFF_FFFF;

    // number of closing square-and-add rounds
    localparam int FINAL_ROUNDS = 3;

    // status of the serial modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/modular_byte_hash.sv =====
// top level of the modular byte hash: ports, modulus register, digest register
`timescale 1ns / 1ps
`default_nettype none

// Hashes a byte stream modulo a configurable modulus, kept in a register written
// through the cfg channel; the user must write it only while the block is idle,
// as the block itself does not enforce this. Every step runs through one
// bit-serial modular multiplier, so the multiplier sets the rate. A byte costs a
// multiply by byte+1, plus a squaring when the byte index is a multiple of four,
// plus a multiply for the round constant while the index is below
// CONSTANT_ROUNDS, plus a reduction when the stored value is not below a newly
// written modulus, plus an idle state in which the next beat is taken. The last
// beat adds three final rounds before the digest appears on the master side. A
// new beat is taken once the previous one has finished; a digest waiting on the
// master side does not hold off input until the next digest is ready.
module modular_byte_hash
    import mbh_pkg::*;
#(
    parameter int VALUE_WIDTH     = VALUE_WIDTH_DEF,
    parameter int CONSTANT_ROUNDS = CONSTANT_ROUNDS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration write
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [MOD_FIELD_W-1:0] cfg_data,      // modulus
    // input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [BYTE_W-1:0]      s_axis_tdata,  // data_byte
    input  wire logic                   s_axis_tuser,  // byte_present
    input  wire logic                   s_axis_tlast,  // last_byte
    // digest stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata   // digest[62:0], zero pad
);

    localparam int W  = VALUE_WIDTH;
    localparam int BW = (VALUE_WIDTH > 9) ? VALUE_WIDTH : 9;
    localparam int CW = $clog2(BW + 1);

    logic [W-1:0]  mod_reg;
    logic [W-1:0]  m_eff;
    logic [W-1:0]  digest_reg;
    logic          out_valid_reg;
    logic          out_free, out_load;
    logic [W-1:0]  out_value;

    logic          mm_start;
    logic [W-1:0]  mm_a, mm_res;
    logic [BW-1:0] mm_b;
    logic [CW-1:0] mm_n;
    mm_status_t    mm_st;

    // modulus register, zero acts as one
    assign cfg_ready = 1'b1;
    assign m_eff     = (mod_reg == '0) ? W'(1) : mod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_reg <= W'(MODULUS_RESET);
        else if (cfg_valid && cfg_ready)
            mod_reg <= W'(cfg_data);
    end

    // digest output register
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            digest_reg <= out_value;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(digest_reg);

    // sequencer
    mbh_seq #(
        .W      (W),
        .ROUNDS (CONSTANT_ROUNDS),
        .BW     (BW),
        .CW     (CW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .m          (m_eff),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_present (s_axis_tuser),
        .in_last    (s_axis_tlast),
        .out_free   (out_free),
        .out_load   (out_load),
        .out_value  (out_value),
        .mm_start   (mm_start),
        .mm_a       (mm_a),
        .mm_b       (mm_b),
        .mm_n       (mm_n),
        .mm_res     (mm_res),
        .mm_st      (mm_st)
    );

    // shared serial multiplier
    mbh_mulmod #(
        .W  (W),
        .BW (BW),
        .CW (CW)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .m      (m_eff),
        .start  (mm_start),
        .a      (mm_a),
        .b      (mm_b),
        .nbits  (mm_n),
        .res    (mm_res),
        .status (mm_st)
    );

    // input is only taken with the multiplier at rest
    a_ready_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !mm_st.busy)
        else $error("input ready while multiplier busy");

    // a started multiplication never overlaps a running one
    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        mm_start |-> (!mm_st.busy || mm_st.done))
        else $error("multiplier restarted while busy");

    // multiplier completion is a single-cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        mm_st.done |=> !mm_st.done)
        else $error("multiplier done held for two cycles");

    // a delivered digest is a residue of the modulus
    a_digest_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (digest_reg < m_eff))
        else $error("digest not reduced");

endmodule

`default_nettype wire

// ===== hw/rtl/mbh_mulmod.sv =====
// bit-serial modular multiplier: acc = a * b mod m, one bit of b per cycle
`timescale 1ns / 1ps
`default_nettype none

module mbh_mulmod
    import mbh_pkg::*;
#(
    parameter int W  = VALUE_WIDTH_DEF,
    parameter int BW = (VALUE_WIDTH_DEF > 9) ? VALUE_WIDTH_DEF : 9,
    parameter int CW = $clog2(BW + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [W-1:0]  m,       // modulus, nonzero
    input  wire logic          start,
    input  wire logic [W-1:0]  a,       // must be below m
    input  wire logic [BW-1:0] b,       // msb-aligned multiplier bits
    input  wire logic [CW-1:0] nbits,   // number of multiplier bits to use
    output logic      [W-1:0]  res,
    output mm_status_t         status
);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  a_reg;
    logic [BW-1:0] b_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;

    logic [W:0] dbl, dbl_red, sum, sum_red;

    // one step: double mod m, then add a mod m when the bit is set
    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
        sum     = {1'b0, dbl_red[W-1:0]} + {1'b0, a_reg};
        sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
        acc_next = b_reg[BW-1] ? sum_red[W-1:0] : dbl_red[W-1:0];
    end

    // operand registers and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[BW-2:0], 1'b0};
        end
    end

    // bit counter and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                cnt_reg  <= nbits;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg  <= cnt_reg - CW'(1);
                busy_reg <= (cnt_reg != CW'(1));
            end
        end
    end

    assign res         = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mbh_seq.sv =====
// sequencer: hash state and the order of multiply, square and add steps
`timescale 1ns / 1ps
`default_nettype none

module mbh_seq
    import mbh_pkg::*;
#(
    parameter int W      = VALUE_WIDTH_DEF,
    parameter int ROUNDS = CONSTANT_ROUNDS_DEF,
    parameter int BW     = (VALUE_WIDTH_DEF > 9) ? VALUE_WIDTH_DEF : 9,
    parameter int CW     = $clog2(BW + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [W-1:0]      m,
    // input beat
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              in_present,
    input  wire logic              in_last,
    // digest hand-off
    input  wire logic              out_free,
    output logic                   out_load,
    output logic      [W-1:0]      out_value,
    // multiplier command
    output logic                   mm_start,
    output logic      [W-1:0]      mm_a,
    output logic      [BW-1:0]     mm_b,
    output logic      [CW-1:0]     mm_n,
    input  wire logic [W-1:0]      mm_res,
    input  wire mm_status_t        mm_st
);

    localparam int IDX_W = $clog2(ROUNDS + 1);
    localparam int KW2   = 2 * IDX_W + 1;
    localparam int RC_W  = $clog2((ROUNDS - 1) * (ROUNDS - 1) + 2);
    localparam int BP1_W = BYTE_W + 1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RED  = 9'b000000010,
        S_MULB = 9'b000000100,
        S_SQR  = 9'b000001000,
        S_RCR  = 9'b000010000,
        S_ADD  = 9'b000100000,
        S_FSQ  = 9'b001000000,
        S_FRC  = 9'b010000000,
        S_FADD = 9'b100000000
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    logic [W-1:0]      v_reg, v_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [1:0]        ph_reg, ph_next;
    logic [1:0]        kf_reg, kf_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              pres_reg, pres_next;
    logic              last_reg, last_next;

    logic [W-1:0]      one_m;
    logic [W:0]        add_sum, add_red;
    logic [W-1:0]      v_add;
    logic [IDX_W-1:0]  fk, k_sel;
    logic [KW2-1:0]    rc_wide;
    logic [RC_W-1:0]   rc;
    logic [BP1_W-1:0]  bp1;
    logic              idx_open;

    // one reduced modulo m, and the modular add with the last multiplier result
    always_comb
    begin
        one_m   = (m == W'(1)) ? '0 : W'(1);
        add_sum = {1'b0, v_reg} + {1'b0, mm_res};
        add_red = (add_sum >= {1'b0, m}) ? add_sum - {1'b0, m} : add_sum;
        v_add   = add_red[W-1:0];
    end

    assign out_value = v_add;
    assign idx_open  = (idx_reg < IDX_W'(ROUNDS));

    // final round k uses constant number k mod ROUNDS
    always_comb
    begin
        if (ROUNDS == 1)
            fk = '0;
        else if (ROUNDS == 2 && kf_reg == 2'd2)
            fk = '0;
        else
            fk = IDX_W'(kf_reg);
    end

    // state transitions
    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        idx_next   = idx_reg;
        ph_next    = ph_reg;
        kf_next    = kf_reg;
        byte_next  = byte_reg;
        pres_next  = pres_reg;
        last_next  = last_reg;
        mm_start   = 1'b0;
        in_ready   = 1'b0;
        out_load   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (in_present || in_last))
                begin
                    byte_next = in_byte;
                    pres_next = in_present;
                    last_next = in_last;
                    mm_start  = 1'b1;
                    kf_next   = 2'd0;
                    if (v_reg >= m)
                        state_next = S_RED;
                    else if (in_present)
                        state_next = S_MULB;
                    else
                        state_next = S_FSQ;
                end
            end
            S_RED:
            begin
                if (mm_st.done)
                begin
                    v_next     = mm_res;
                    mm_start   = 1'b1;
                    state_next = pres_reg ? S_MULB : S_FSQ;
                end
            end
            S_MULB, S_SQR:
            begin
                if (mm_st.done)
                begin
                    v_next = mm_res;
                    if (state_reg == S_MULB && ph_reg == 2'd0)
                    begin
                        mm_start   = 1'b1;
                        state_next = S_SQR;
                    end
                    else if (idx_open)
                    begin
                        mm_start   = 1'b1;
                        state_next = S_RCR;
                    end
                    else
                    begin
                        ph_next = ph_reg + 2'd1;
                        if (last_reg)
                        begin
                            mm_start   = 1'b1;
                            state_next = S_FSQ;
                        end
                        else
                            state_next = S_IDLE;
                    end
                end
            end
            S_RCR:
            begin
                if (mm_st.done)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                v_next   = v_add;
                idx_next = idx_reg + IDX_W'(1);
                ph_next  = ph_reg + 2'd1;
                if (last_reg)
                begin
                    mm_start   = 1'b1;
                    state_next = S_FSQ;
                end
                else
                    state_next = S_IDLE;
            end
            S_FSQ:
            begin
                if (mm_st.done)
                begin
                    v_next     = mm_res;
                    mm_start   = 1'b1;
                    state_next = S_FRC;
                end
            end
            S_FRC:
            begin
                if (mm_st.done)
                    state_next = S_FADD;
            end
            S_FADD:
            begin
                if (kf_reg == 2'(FINAL_ROUNDS - 1))
                begin
                    // digest leaves, hash value, index and phase return to their reset values
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        v_next     = W'(1);
                        idx_next   = '0;
                        ph_next    = 2'd0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    v_next     = v_add;
                    kf_next    = kf_reg + 2'd1;
                    mm_start   = 1'b1;
                    state_next = S_FSQ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // operands of the multiplier step being launched
    always_comb
    begin
        k_sel   = (state_next == S_FRC) ? fk : idx_reg;
        rc_wide = KW2'(k_sel) * KW2'(k_sel) + KW2'(1);
        rc      = rc_wide[RC_W-1:0];
        bp1     = BP1_W'(byte_next) + BP1_W'(1);

        mm_a = v_next;
        mm_b = BW'(v_next) << (BW - W);
        mm_n = CW'(W);
        unique case (state_next)
            S_RED:
            begin
                mm_a = one_m;
            end
            S_MULB:
            begin
                mm_b = BW'(bp1) << (BW - BP1_W);
                mm_n = CW'(BP1_W);
            end
            S_RCR, S_FRC:
            begin
                mm_a = one_m;
                mm_b = BW'(rc) << (BW - RC_W);
                mm_n = CW'(RC_W);
            end
            default:
            begin
                mm_a = v_next;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            v_reg     <= W'(1);
            idx_reg   <= '0;
            ph_reg    <= 2'd0;
            kf_reg    <= 2'd0;
            pres_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v_reg     <= v_next;
            idx_reg   <= idx_next;
            ph_reg    <= ph_next;
            kf_reg    <= kf_next;
            pres_reg  <= pres_next;
            last_reg  <= last_next;
        end
    end

    // byte of the current beat
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

`default_nettype wire

// ===== tb/modular_byte_hash_tb.sv =====
// self-checking testbench for the modular byte hash with its own digest predictor
`timescale 1ns / 1ps

module modular_byte_hash_tb
    import mbh_pkg::*;
();

    localparam int  HALF_PERIOD   = 6;
    localparam int  SETTLE_CYCLES = 400;      // longer than one byte plus the final rounds
    localparam int  HOLD_CYCLES   = 3000;     // long receiver stall
    localparam int  CYCLE_LIMIT   = 3000000;
    localparam int  PHASE_ITEMS   = 112;
    localparam int  GAP_PERCENT   = 7;
    localparam int  NUM_SETTINGS  = 12;

    typedef struct {
        logic [BYTE_W-1:0] data_byte;
        logic              byte_present;
        logic              last_byte;
    } hash_beat_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [MOD_FIELD_W-1:0] cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata = '0;   // data_byte
    logic                   s_axis_tuser = 1'b0; // byte_present
    logic                   s_axis_tlast = 1'b0; // last_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // digest[62:0], zero pad

    // predictor state
    logic [MOD_FIELD_W-1:0] active_modulus = MODULUS_RESET;
    logic [MOD_FIELD_W-1:0] chain_value = 1;
    int                     chain_index = 0;
    logic [1:0]             chain_phase = 2'd0;

    hash_beat_t             beat_feed [$];
    logic [MOD_FIELD_W-1:0] pending_digests [$];
    hash_beat_t             offered;
    logic                   beat_on_bus = 1'b0;
    logic                   gaps_off = 1'b0;
    logic                   hold_request = 1'b0;
    int                     hold_left = 0;
    int                     queued_items = 0;
    int                     messages_queued = 0;
    int                     digests_checked = 0;
    int                     mismatch_count = 0;
    int                     modulus_writes = 0;
    int                     cycle_count = 0;

    modular_byte_hash dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // (a * b) mod m with a, b below m
    function automatic logic [MOD_FIELD_W-1:0] mul_residue(
        input logic [MOD_FIELD_W-1:0] a,
        input logic [MOD_FIELD_W-1:0] b,
        input logic [MOD_FIELD_W-1:0] m
    );
        logic [2*MOD_FIELD_W-1:0] prod;
        prod = {{MOD_FIELD_W{1'b0}}, a} * {{MOD_FIELD_W{1'b0}}, b};
        prod = prod % {{MOD_FIELD_W{1'b0}}, m};
        return prod[MOD_FIELD_W-1:0];
    endfunction

    // (a + (k*k+1 mod m)) mod m with a below m
    function automatic logic [MOD_FIELD_W-1:0] add_round_const(
        input logic [MOD_FIELD_W-1:0] a,
        input int                     k,
        input logic [MOD_FIELD_W-1:0] m
    );
        logic [63:0] c;
        logic [63:0] sum;
        c = 64'(k * k + 1) % {1'b0, m};
        sum = {1'b0, a} + c;
        if (sum >= {1'b0, m})
            sum = sum - {1'b0, m};
        return sum[MOD_FIELD_W-1:0];
    endfunction

    // fold one accepted beat into the chain, queue a digest on the last beat
    task automatic absorb_beat(input hash_beat_t beat);
        logic [MOD_FIELD_W-1:0] m;
        logic [MOD_FIELD_W-1:0] v;
        logic [MOD_FIELD_W-1:0] factor;
        m = (active_modulus == '0) ? MOD_FIELD_W'(1) : active_modulus;
        v = chain_value % m;
        if (beat.byte_present)
        begin
            factor = (MOD_FIELD_W'(beat.data_byte) + 1) % m;
            v = mul_residue(v, factor, m);
            if (chain_phase == 2'd0)
                v = mul_residue(v, v, m);
            if (chain_index < CONSTANT_ROUNDS_DEF)
            begin
                v = add_round_const(v, chain_index, m);
                chain_index++;
            end
            chain_phase = chain_phase + 2'd1;
        end
        chain_value = v;
        if (beat.last_byte)
        begin
            for (int k = 0; k < FINAL_ROUNDS; k++)
                v = add_round_const(mul_residue(v, v, m), k % CONSTANT_ROUNDS_DEF, m);
            pending_digests = {pending_digests, v};
            chain_value = 1;
            chain_index = 0;
            chain_phase = 2'd0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic queue_beat(input logic [7:0] b, input logic present, input logic last);
        hash_beat_t beat;
        beat.data_byte = b;
        beat.byte_present = present;
        beat.last_byte = last;
        beat_feed = {beat_feed, beat};
        queued_items++;
        if (last)
            messages_queued++;
    endtask

    // random message: mostly short, some past the round constants, a few empty
    task automatic queue_message();
        int  pick;
        int  n;
        logic empty_end;
        pick = $urandom_range(99);
        if (pick < 5)
            n = 0;
        else if (pick < 70)
            n = $urandom_range(8, 1);
        else if (pick < 95)
            n = $urandom_range(24, 9);
        else
            n = $urandom_range(40, 25);
        empty_end = (n == 0) || ($urandom_range(99) < 15);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 5)
                queue_beat(8'($urandom_range(255)), 1'b0, 1'b0);
            queue_beat(8'($urandom_range(255)), 1'b1, !empty_end && (i == n - 1));
        end
        if (empty_end)
            queue_beat(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // sender pause: everything sent and every digest back, then let the block settle
    task automatic wait_idle();
        while (beat_feed.size() != 0 || beat_on_bus || pending_digests.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_modulus(input logic [MOD_FIELD_W-1:0] value);
        @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        active_modulus = value;
        modulus_writes++;
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_beat(offered);
                beat_on_bus = 1'b0;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (beat_feed.size() != 0 && (gaps_off || $urandom_range(99) >= GAP_PERCENT))
                begin
                    offered = beat_feed.pop_front();
                    beat_on_bus = 1'b1;
                    s_axis_tdata  <= offered.data_byte;
                    s_axis_tuser  <= offered.byte_present;
                    s_axis_tlast  <= offered.last_byte;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // digest receiver, with one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= rst_n && (gaps_off || $urandom_range(99) >= GAP_PERCENT);
        end
    end

    // digest checker
    always @(posedge clk)
    begin
        logic [MOD_FIELD_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_digests.size() == 0)
            begin
                report_mismatch($sformatf("digest %h with none expected",
                                          m_axis_tdata[MOD_FIELD_W-1:0]));
            end
            else
            begin
                want = pending_digests.pop_front();
                digests_checked++;
                if (m_axis_tdata[MOD_FIELD_W-1:0] !== want)
                    report_mismatch($sformatf("digest %h, expected %h",
                                              m_axis_tdata[MOD_FIELD_W-1:0], want));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        logic [MOD_FIELD_W-1:0] settings [NUM_SETTINGS];
        logic [63:0]            wide;
        int                     phase_base;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, byte extremes, idle items, empty end
        queue_beat(8'h00, 1'b0, 1'b1);
        queue_beat(8'h00, 1'b1, 1'b1);
        queue_beat(8'hFF, 1'b1, 1'b1);
        queue_beat(8'hA5, 1'b0, 1'b0);
        queue_beat(8'h80, 1'b1, 1'b0);
        queue_beat(8'h5A, 1'b0, 1'b0);
        queue_beat(8'h7F, 1'b1, 1'b1);
        queue_beat(8'h01, 1'b1, 1'b0);
        queue_beat(8'h02, 1'b1, 1'b0);
        queue_beat(8'h03, 1'b1, 1'b0);
        queue_beat(8'h04, 1'b1, 1'b0);
        queue_beat(8'hFE, 1'b1, 1'b0);
        queue_beat(8'h3C, 1'b0, 1'b1);

        // directed: modulus shrinks in the middle of a message
        queue_beat(8'h11, 1'b1, 1'b0);
        queue_beat(8'h22, 1'b1, 1'b0);
        queue_beat(8'h33, 1'b1, 1'b0);
        wait_idle();
        write_modulus(63'd1000003);
        queue_beat(8'h44, 1'b1, 1'b0);
        queue_beat(8'h55, 1'b1, 1'b1);

        // modulus settings for the random phases, extremes included
        settings[0]  = 63'd0;
        settings[1]  = 63'd1;
        settings[2]  = 63'd2;
        settings[3]  = 63'd3;
        settings[4]  = 63'd251;
        settings[5]  = 63'd65537;
        settings[6]  = 63'h7FFF_FFFF_FFFF_FFFF;
        settings[7]  = MODULUS_RESET;
        settings[8]  = MOD_FIELD_W'($urandom());
        wide = {$urandom(), $urandom()};
        settings[9]  = wide[MOD_FIELD_W-1:0];
        settings[10] = 63'h4000_0000_0000_0001;
        wide = {$urandom(), $urandom()};
        settings[11] = wide[MOD_FIELD_W-1:0] | 63'h4000_0000_0000_0000;

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            wait_idle();
            write_modulus(settings[p]);
            gaps_off = (p == 6);
            if (p == 4)
                hold_request = 1'b1;
            phase_base = queued_items;
            while (queued_items - phase_base < PHASE_ITEMS)
                queue_message();
        end

        wait_idle();
        $display("covered %0d input beats in %0d messages under %0d modulus writes",
                 queued_items, messages_queued, modulus_writes);
        $display("%0d digests compared, %0d mismatches", digests_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
